FILE: sv/handheld_memory_bus_decoder_top_assert.svh
// Assertion macros used by the decoder pipeline module hmbd_pipe.
// Each macro samples on clk and is switched off while arst_n is low.
`ifndef HANDHELD_MEMORY_BUS_DECODER_TOP_ASSERT_SVH
`define HANDHELD_MEMORY_BUS_DECODER_TOP_ASSERT_SVH

// cond in a cycle implies expr in the same cycle
`define HMBD_ASSERT_IMPLY(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// cond in a cycle implies expr in the next cycle
`define HMBD_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

FILE: sv/hmbd_pkg.sv
`timescale 1ns / 1ps
package hmbd_pkg;

	// unified store: video RAM, work RAM, spare store, then sprite table and FFxx page
	localparam int unsigned MemDepth = 25088;
	localparam int unsigned MemAddrW = 15;
	typedef logic [MemAddrW-1:0] mem_idx_t;

	localparam logic [1:0] REGION_VRAM  = 2'd0;
	localparam logic [1:0] REGION_WRAM  = 2'd1;
	localparam logic [1:0] REGION_SPARE = 2'd2;
	localparam logic [1:0] REGION_SMALL = 2'd3;
	localparam logic [4:0] PAGE_SPRITE  = 5'd0;
	localparam logic [4:0] PAGE_HIGH    = 5'd1;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_INTR  = 2'd2;

	localparam logic [1:0] TGT_INTERNAL = 2'd0;
	localparam logic [1:0] TGT_BOOT     = 2'd1;
	localparam logic [1:0] TGT_CART     = 2'd2;
	localparam logic [1:0] TGT_JOYPAD   = 2'd3;

	localparam int unsigned ApbAddrW = 3;
	localparam int unsigned ApbDataW = 32;
	localparam logic CFG_CART_LOADED = 1'b0;

	localparam logic [15:0] ADDR_BOOT_END    = 16'h0100;
	localparam logic [15:0] ADDR_ROM_LAST    = 16'h7FFF;
	localparam logic [15:0] ADDR_VRAM_LAST   = 16'h9FFF;
	localparam logic [15:0] ADDR_CRAM_LAST   = 16'hBFFF;
	localparam logic [15:0] ADDR_WRAM_LAST   = 16'hDFFF;
	localparam logic [15:0] ADDR_SPRITE_FIRST = 16'hFE00;
	localparam logic [15:0] ADDR_SPRITE_LAST = 16'hFE9F;
	localparam logic [15:0] ADDR_JOYPAD      = 16'hFF00;
	localparam logic [15:0] ADDR_DIV         = 16'hFF04;
	localparam logic [15:0] ADDR_IF          = 16'hFF0F;
	localparam logic [15:0] ADDR_BOOT_OFF    = 16'hFF50;
	localparam logic [7:0]  BOOT_OFF_VALUE   = 8'h01;

	localparam mem_idx_t IF_IDX = {REGION_SMALL, PAGE_HIGH, ADDR_IF[7:0]};

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  ext_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] target;
		logic       ext_write;
	} rsp_t;

	typedef struct packed {
		logic       rd_en;
		mem_idx_t   rd_idx;
		logic       wr_en;
		mem_idx_t   wr_idx;
		logic [7:0] wr_data;
	} mem_req_t;

	typedef enum logic [2:0] {
		AREA_ROM,
		AREA_VRAM,
		AREA_CRAM,
		AREA_WRAM,
		AREA_SPRITE,
		AREA_JOYPAD,
		AREA_HIGH,
		AREA_SPARE
	} area_t;

	function automatic area_t area_of(logic [15:0] a);
		area_t area;
		if (a <= ADDR_ROM_LAST) begin
			area = AREA_ROM;
		end else if (a <= ADDR_VRAM_LAST) begin
			area = AREA_VRAM;
		end else if (a <= ADDR_CRAM_LAST) begin
			area = AREA_CRAM;
		end else if (a <= ADDR_WRAM_LAST) begin
			area = AREA_WRAM;
		end else if (a >= ADDR_SPRITE_FIRST && a <= ADDR_SPRITE_LAST) begin
			area = AREA_SPRITE;
		end else if (a == ADDR_JOYPAD) begin
			area = AREA_JOYPAD;
		end else if (a > ADDR_JOYPAD) begin
			area = AREA_HIGH;
		end else begin
			area = AREA_SPARE;
		end
		return area;
	endfunction

	function automatic mem_idx_t store_index(logic [15:0] a);
		mem_idx_t idx;
		unique case (area_of(a))
			AREA_VRAM:   idx = {REGION_VRAM, a[12:0]};
			AREA_WRAM:   idx = {REGION_WRAM, a[12:0]};
			AREA_SPARE:  idx = {REGION_SPARE, a[12:0]};
			AREA_SPRITE: idx = {REGION_SMALL, PAGE_SPRITE, a[7:0]};
			AREA_HIGH:   idx = {REGION_SMALL, PAGE_HIGH, a[7:0]};
			default:     idx = '0;
		endcase
		return idx;
	endfunction

endpackage

FILE: sv/hmbd_store.sv
`timescale 1ns / 1ps
module hmbd_store (
	input  logic               clk,
	input  logic               arst_n,
	input  hmbd_pkg::mem_req_t mem_req,
	output logic [7:0]         rd_data,
	output logic               busy
);
	import hmbd_pkg::*;

	logic [7:0] mem [MemDepth];
	logic [7:0] rd_data_q;
	mem_idx_t   clr_idx_q;
	logic       busy_q;

	// sweep zeros through every entry after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_idx_q == mem_idx_t'(MemDepth - 1)) begin
				busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (mem_req.wr_en) begin
			mem[mem_req.wr_idx] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rd_data_q <= mem[mem_req.rd_idx];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

FILE: sv/hmbd_pipe.sv
`timescale 1ns / 1ps
`include "handheld_memory_bus_decoder_top_assert.svh"
module hmbd_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cart_loaded,
	input  logic               req_valid,
	output logic               req_ready,
	input  hmbd_pkg::req_t     req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output hmbd_pkg::rsp_t     rsp,
	output hmbd_pkg::mem_req_t mem_req,
	input  logic [7:0]         rd_data,
	input  logic               busy
);
	import hmbd_pkg::*;

	req_t       item_s1;
	mem_idx_t   idx_s1;
	logic       valid_s1;
	logic       boot_q;
	logic       fwd_valid_q;
	mem_idx_t   fwd_idx_q;
	logic [7:0] fwd_data_q;
	logic       rsp_valid_q;
	rsp_t       rsp_q;

	logic       advance;
	logic       accept;
	mem_idx_t   acc_idx;
	logic [7:0] cur_data;
	area_t      area;
	rsp_t       rsp_nxt;
	logic       wr_en_c;
	logic [7:0] wr_data_c;
	logic       boot_clr;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !busy && (!valid_s1 || advance);
	assign accept    = req_valid && req_ready;
	assign acc_idx   = (req.cmd == CMD_INTR) ? IF_IDX : store_index(req.address);
	// last write to this entry wins, also one landing on the read edge
	assign cur_data  = (fwd_valid_q && fwd_idx_q == idx_s1) ? fwd_data_q : rd_data;
	assign area      = area_of(item_s1.address);

	always_comb begin
		rsp_nxt   = '0;
		wr_en_c   = 1'b0;
		wr_data_c = item_s1.write_data;
		boot_clr  = 1'b0;
		unique case (item_s1.cmd)
			CMD_READ: begin
				unique case (area)
					AREA_ROM: begin
						if (item_s1.address < ADDR_BOOT_END && boot_q) begin
							rsp_nxt.read_data = item_s1.ext_data;
							rsp_nxt.target    = TGT_BOOT;
						end else if (cart_loaded) begin
							rsp_nxt.read_data = item_s1.ext_data;
							rsp_nxt.target    = TGT_CART;
						end
					end
					AREA_CRAM: begin
						rsp_nxt.read_data = item_s1.ext_data;
						rsp_nxt.target    = TGT_CART;
					end
					AREA_JOYPAD: begin
						rsp_nxt.read_data = item_s1.ext_data;
						rsp_nxt.target    = TGT_JOYPAD;
					end
					default: begin
						rsp_nxt.read_data = cur_data;
					end
				endcase
			end
			CMD_WRITE: begin
				unique case (area)
					AREA_ROM, AREA_CRAM: begin
						rsp_nxt.target    = TGT_CART;
						rsp_nxt.ext_write = 1'b1;
					end
					AREA_JOYPAD: begin
						rsp_nxt.target    = TGT_JOYPAD;
						rsp_nxt.ext_write = 1'b1;
					end
					default: begin
						wr_en_c = 1'b1;
						if (item_s1.address == ADDR_DIV) begin
							wr_data_c = '0;
						end
						if (item_s1.address == ADDR_BOOT_OFF &&
						    item_s1.write_data == BOOT_OFF_VALUE) begin
							boot_clr = 1'b1;
						end
					end
				endcase
			end
			CMD_INTR: begin
				wr_en_c   = 1'b1;
				wr_data_c = cur_data | item_s1.write_data;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_req.rd_en   = accept;
		mem_req.rd_idx  = acc_idx;
		mem_req.wr_en   = advance && wr_en_c;
		mem_req.wr_idx  = idx_s1;
		mem_req.wr_data = wr_data_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			boot_q      <= 1'b1;
			fwd_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (advance && boot_clr) begin
				boot_q <= 1'b0;
			end
			if (mem_req.wr_en) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
			idx_s1  <= acc_idx;
		end
		if (advance) begin
			rsp_q <= rsp_nxt;
		end
		if (mem_req.wr_en) begin
			fwd_idx_q  <= mem_req.wr_idx;
			fwd_data_q <= mem_req.wr_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`HMBD_ASSERT_IMPLY(a_no_accept_in_clear, busy, !req_ready, "word accepted during clear")
	`HMBD_ASSERT_IMPLY(a_no_write_in_stall, valid_s1 && rsp_valid_q && !rsp_ready,
		!mem_req.wr_en, "store written while result stalled")
	`HMBD_ASSERT_NEXT(a_boot_stays_off, !boot_q, !boot_q, "boot ROM remapped")
	`HMBD_ASSERT_IMPLY(a_ext_write_target, rsp_valid_q && rsp_q.ext_write,
		rsp_q.target != TGT_INTERNAL, "external write with internal target")

endmodule

FILE: sv/handheld_memory_bus_decoder_top.sv
`timescale 1ns / 1ps
// Memory bus decoder for a handheld console memory map.
// Request channel (req_valid/req_ready/req) takes one bus word per cycle
// when req_ready is high: a read, a write or an interrupt request. Response
// channel (rsp_valid/rsp_ready/rsp) returns one word for each request, in
// order. Boot ROM, cartridge and joypad data arrive with the request in
// ext_data; the response names the target and flags forwarded writes. An
// accepted request is registered with its store read data; its response
// enters the output register as it advances. Throughput: one word per
// cycle sustained while rsp_ready is high, set by the single read port
// and single write port of the unified store; the read-modify-write of
// an interrupt on the flag register is covered by forwarding of the last
// write, so it does not stall. Reset: the store is swept to zero one entry
// a cycle with req_ready low; boot ROM is mapped and cartridge_loaded is 0.
// Configuration: APB register cartridge_loaded at byte address 0.
// Stall: while rsp_ready is low a finished response waits in the output
// register; one more request may enter and hold its read data, then
// req_ready drops until the response is taken.
module handheld_memory_bus_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  hmbd_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output hmbd_pkg::rsp_t                    rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hmbd_pkg::ApbAddrW-1:0]     paddr,
	input  logic [hmbd_pkg::ApbDataW-1:0]     pwdata,
	output logic [hmbd_pkg::ApbDataW-1:0]     prdata,
	output logic                              pready
);
	import hmbd_pkg::*;

	logic       cart_q;
	logic       cfg_wr;
	mem_req_t   mem_req;
	logic [7:0] rd_data;
	logic       busy;

	// register index is the word address
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_q <= 1'b0;
		end else if (cfg_wr && paddr[ApbAddrW-1] == CFG_CART_LOADED) begin
			cart_q <= pwdata[0];
		end
	end

	// read back the register; holes read zero
	assign prdata = (paddr[ApbAddrW-1] == CFG_CART_LOADED) ?
		{{(ApbDataW-1){1'b0}}, cart_q} : '0;

	hmbd_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.cart_loaded (cart_q),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mem_req     (mem_req),
		.rd_data     (rd_data),
		.busy        (busy)
	);

	hmbd_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rd_data (rd_data),
		.busy    (busy)
	);

endmodule
